/* design/rfs_pkg.sv */
// Shared types and constants for the Q15 real-FFT split butterfly.
package rfs_pkg;

	// Q15 sample word
	typedef logic signed [15:0] sample_t;

	// Full-precision product of two samples
	typedef logic signed [31:0] prod_t;

	// Halving scale and its rounding offset
	localparam logic signed [15:0] HALF_SCALE = 16'sd16383;
	localparam logic signed [31:0] HALF_ROUND = 32'sd16384;

	// Q15 fraction bits
	localparam int unsigned QSHIFT = 15;

	// Rounding offset for the twiddle product
	localparam logic signed [33:0] TW_ROUND = 34'sd16384;

	// Saturation limits
	localparam logic signed [18:0] SAT_MAX = 19'sd32767;
	localparam logic signed [18:0] SAT_MIN = -19'sd32768;

endpackage

/* design/rfs_halve.sv */
// First stage: conjugates the far bin and halves all four bin parts.
module rfs_halve (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            valid,
	input  rfs_pkg::sample_t low_re,
	input  rfs_pkg::sample_t low_im,
	input  rfs_pkg::sample_t high_re,
	input  rfs_pkg::sample_t high_im,
	output logic            valid_s1,
	output rfs_pkg::sample_t ar_s1,
	output rfs_pkg::sample_t ai_s1,
	output rfs_pkg::sample_t br_s1,
	output rfs_pkg::sample_t bi_s1
);

	// (x*16383 + 16384) >>> 15, floor shift
	function automatic rfs_pkg::sample_t halve(input rfs_pkg::sample_t x);
		rfs_pkg::prod_t prod;
		rfs_pkg::prod_t sum;
		rfs_pkg::prod_t shr;
		prod = x * rfs_pkg::HALF_SCALE;
		sum  = prod + rfs_pkg::HALF_ROUND;
		shr  = sum >>> rfs_pkg::QSHIFT;
		return shr[15:0];
	endfunction

	rfs_pkg::sample_t conj_im;

	// conjugate wraps: the most negative value stays put
	assign conj_im = 16'sd0 - high_im;

	// valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= valid;
		end
	end

	// halved parts
	always_ff @(posedge clk) begin
		ar_s1 <= halve(low_re);
		ai_s1 <= halve(low_im);
		br_s1 <= halve(high_re);
		bi_s1 <= halve(conj_im);
	end

endmodule

/* design/rfs_twmul.sv */
// Complex twiddle multiply: products, then round, shift and saturate.
module rfs_twmul (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            valid,
	input  rfs_pkg::sample_t f2r,
	input  rfs_pkg::sample_t f2i,
	input  rfs_pkg::sample_t wr,
	input  rfs_pkg::sample_t wi,
	output logic            valid_s4,
	output rfs_pkg::sample_t tr_s4,
	output rfs_pkg::sample_t ti_s4
);

	logic           valid_s3;
	rfs_pkg::prod_t rr_s3, ii_s3, ri_s3, ir_s3;
	logic signed [33:0] pr, pi;
	logic signed [33:0] pr_sh, pi_sh;

	// shift and clamp to 16 bits; the rounding offset is already added into v
	function automatic rfs_pkg::sample_t rnd_sat(input logic signed [33:0] v);
		logic signed [18:0] n;
		n = v[33:15];
		if (n > rfs_pkg::SAT_MAX) begin
			return rfs_pkg::SAT_MAX[15:0];
		end else if (n < rfs_pkg::SAT_MIN) begin
			return rfs_pkg::SAT_MIN[15:0];
		end
		return n[15:0];
	endfunction

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s3 <= valid;
			valid_s4 <= valid_s3;
		end
	end

	// partial products
	always_ff @(posedge clk) begin
		rr_s3 <= f2r * wr;
		ii_s3 <= f2i * wi;
		ri_s3 <= f2r * wi;
		ir_s3 <= f2i * wr;
	end

	// combine and round
	assign pr    = 34'(rr_s3) - 34'(ii_s3) + rfs_pkg::TW_ROUND;
	assign pi    = 34'(ri_s3) + 34'(ir_s3) + rfs_pkg::TW_ROUND;
	assign pr_sh = pr;
	assign pi_sh = pi;

	always_ff @(posedge clk) begin
		tr_s4 <= rnd_sat(pr_sh);
		ti_s4 <= rnd_sat(pi_sh);
	end

`ifndef SYNTHESIS
	// an item entering the multiplier leaves it through the product and round/saturate registers
	a_twmul_lat: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> ##2 valid_s4)
		else $error("twiddle multiplier lost an item");
	a_twmul_src: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 |-> $past(valid, 2))
		else $error("twiddle multiplier invented an item");
`endif

endmodule

/* design/real_fft_split_q15.sv */
// Each accepted start gives one done strobe, set from the final-add stage register.
// Throughput: one item per cycle; five register stages (halve, sum/difference,
// twiddle products, round/saturate, final add) limit the clock, not the rate.
// busy is always low, results are never held off by the receiver.
// Reset (arst_n low, asynchronous) clears every valid bit; items in flight are dropped.
module real_fft_split_q15 (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  rfs_pkg::sample_t low_re,
	input  rfs_pkg::sample_t low_im,
	input  rfs_pkg::sample_t high_re,
	input  rfs_pkg::sample_t high_im,
	input  rfs_pkg::sample_t twiddle_re,
	input  rfs_pkg::sample_t twiddle_im,
	input  logic             dc_bin,
	output logic             done,
	output rfs_pkg::sample_t low_out_re,
	output rfs_pkg::sample_t low_out_im,
	output rfs_pkg::sample_t high_out_re,
	output rfs_pkg::sample_t high_out_im
);

	logic             accept;
	logic             valid_s1, valid_s2, valid_s4, valid_s5;
	rfs_pkg::sample_t ar_s1, ai_s1, br_s1, bi_s1;
	rfs_pkg::sample_t wr_s1, wi_s1, wr_s2, wi_s2;
	logic             dc_s1, dc_s2, dc_s3, dc_s4;
	rfs_pkg::sample_t f1r_s2, f1i_s2, f2r_s2, f2i_s2;
	rfs_pkg::sample_t f1r_s3, f1i_s3, f1r_s4, f1i_s4;
	rfs_pkg::sample_t tr_s4, ti_s4;
	rfs_pkg::sample_t lo_re_sum, lo_im_sum, hi_re_dif, hi_im_dif;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// stage 1: halving
	rfs_halve u_halve (
		.clk     (clk),
		.arst_n  (arst_n),
		.valid   (accept),
		.low_re  (low_re),
		.low_im  (low_im),
		.high_re (high_re),
		.high_im (high_im),
		.valid_s1(valid_s1),
		.ar_s1   (ar_s1),
		.ai_s1   (ai_s1),
		.br_s1   (br_s1),
		.bi_s1   (bi_s1)
	);

	always_ff @(posedge clk) begin
		wr_s1 <= twiddle_re;
		wi_s1 <= twiddle_im;
		dc_s1 <= dc_bin;
	end

	// stage 2: sum and difference; DC mode puts re+im and re-im in the f1 slots
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (dc_s1) begin
			f1r_s2 <= ar_s1 + ai_s1;
			f1i_s2 <= ar_s1 - ai_s1;
		end else begin
			f1r_s2 <= ar_s1 + br_s1;
			f1i_s2 <= ai_s1 + bi_s1;
		end
		f2r_s2 <= ar_s1 - br_s1;
		f2i_s2 <= ai_s1 - bi_s1;
		wr_s2  <= wr_s1;
		wi_s2  <= wi_s1;
		dc_s2  <= dc_s1;
	end

	// stages 3 and 4: twiddle multiply
	rfs_twmul u_twmul (
		.clk     (clk),
		.arst_n  (arst_n),
		.valid   (valid_s2),
		.f2r     (f2r_s2),
		.f2i     (f2i_s2),
		.wr      (wr_s2),
		.wi      (wi_s2),
		.valid_s4(valid_s4),
		.tr_s4   (tr_s4),
		.ti_s4   (ti_s4)
	);

	// f1 and mode ride alongside the multiplier
	always_ff @(posedge clk) begin
		f1r_s3 <= f1r_s2;
		f1i_s3 <= f1i_s2;
		dc_s3  <= dc_s2;
		f1r_s4 <= f1r_s3;
		f1i_s4 <= f1i_s3;
		dc_s4  <= dc_s3;
	end

	// stage 5: wrapping sums halved by an arithmetic shift; DC mode passes f1 unhalved
	assign lo_re_sum = f1r_s4 + tr_s4;
	assign lo_im_sum = f1i_s4 + ti_s4;
	assign hi_re_dif = f1r_s4 - tr_s4;
	assign hi_im_dif = ti_s4 - f1i_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else begin
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (dc_s4) begin
			low_out_re  <= f1r_s4;
			low_out_im  <= '0;
			high_out_re <= f1i_s4;
			high_out_im <= '0;
		end else begin
			low_out_re  <= lo_re_sum >>> 1;
			low_out_im  <= lo_im_sum >>> 1;
			high_out_re <= hi_re_dif >>> 1;
			high_out_im <= hi_im_dif >>> 1;
		end
	end

	assign done = valid_s5;

`ifndef SYNTHESIS
	// every accepted item gives exactly one done strobe
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##5 done)
		else $error("item lost in pipeline");
	a_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, 5))
		else $error("result with no item behind it");
	// DC items carry zero imaginary parts out
	a_dc: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 && dc_s4 |=> low_out_im == '0 && high_out_im == '0)
		else $error("DC result has non-zero imaginary part");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("pipeline refused an item");
`endif

endmodule
